// ===== rtl/assert_macros.svh =====
// assertion macros shared by the glyph renderer modules
// needs signals named clock and reset in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define GTR_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define GTR_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/gtr_pkg.sv =====
// shared types and constants of the glyph text renderer
// used by gtr_ctrl, gtr_datapath and glyph_text_renderer
package gtr_pkg;

   localparam int GLYPH_ROWS  = 16;
   localparam int GLYPH_COUNT = 256;
   localparam int ROW_W       = $clog2(GLYPH_ROWS);
   localparam int GLYPH_W     = $clog2(GLYPH_COUNT);
   localparam int STORE_DEPTH = GLYPH_COUNT * GLYPH_ROWS;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(GLYPH_ROWS - 1);
   localparam logic [15:0]      CELL_W   = 16'd8;
   localparam logic [15:0]      CELL_H   = 16'd16;
   localparam logic [15:0]      Y_MAX    = 16'hFFFF;

   localparam logic [15:0] PITCH_RESET = 16'd640;
   localparam logic [15:0] WIDTH_RESET = 16'd640;

   // command codes
   localparam logic [1:0] CMD_DRAW = 2'd0;
   localparam logic [1:0] CMD_LOAD = 2'd1;
   localparam logic [1:0] CMD_HOME = 2'd2;

   // register indexes, taken from paddr[2]
   localparam logic REG_LINE_PITCH   = 1'b0;
   localparam logic REG_SCREEN_WIDTH = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_ROWS,
      ST_FINISH
   } ctrl_state_type;

   typedef struct packed {
      logic             latch;
      logic             load;
      logic             home;
      logic             setup;
      logic             read;
      logic             last;
      logic [ROW_W-1:0] row;
      logic             advance;
   } dp_cmd_type;

endpackage

// ===== rtl/glyph_text_renderer.sv =====
// glyph text renderer top level: csr registers, controller and datapath
// depends on gtr_pkg, gtr_ctrl and gtr_datapath
//
// channel   direction  handshake             payload
// req_      in         start & !busy         command, char_code, pen_color, font_address, font_byte
// rsp_      out        rsp_valid, one cycle  pixel_offset, row_mask, out_color, last_row
// csr       in/out     psel penable pwrite   line_pitch @0x0, screen_width @0x4
//
// a draw keeps busy high through setup, for the start offset multiply, then 16 font
// memory reads at one row per cycle, then finish, to advance the cursor
// row transfers come one per cycle, each in the cycle after its font memory read
// load and home take effect at the accepting edge and never raise busy
// reset is synchronous; the cursor clears, the font memory is undefined until loaded
// the receiver cannot stall, so no result is ever held back

module glyph_text_renderer
   import gtr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_command,
   input  logic [7:0]  req_char_code,
   input  logic [31:0] req_pen_color,
   input  logic [11:0] req_font_address,
   input  logic [7:0]  req_font_byte,
   output logic        rsp_valid,
   output logic [31:0] rsp_pixel_offset,
   output logic [7:0]  rsp_row_mask,
   output logic [31:0] rsp_out_color,
   output logic        rsp_last_row,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [15:0] line_pitch_ff;
   logic [15:0] screen_width_ff;
   logic        csr_write;
   dp_cmd_type  dp_cmd;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_pitch_ff   <= PITCH_RESET;
         screen_width_ff <= WIDTH_RESET;
      end else if (csr_write) begin
         unique case (paddr[2])
            REG_LINE_PITCH:   line_pitch_ff   <= pwdata[15:0];
            REG_SCREEN_WIDTH: screen_width_ff <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_LINE_PITCH:   prdata = {16'd0, line_pitch_ff};
         REG_SCREEN_WIDTH: prdata = {16'd0, screen_width_ff};
         default:          prdata = '0;
      endcase
   end

   gtr_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .command (req_command),
      .busy    (busy),
      .dp_cmd  (dp_cmd)
   );

   gtr_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .dp_cmd           (dp_cmd),
      .req_char_code    (req_char_code),
      .req_pen_color    (req_pen_color),
      .req_font_address (req_font_address),
      .req_font_byte    (req_font_byte),
      .line_pitch       (line_pitch_ff),
      .screen_width     (screen_width_ff),
      .rsp_valid        (rsp_valid),
      .rsp_pixel_offset (rsp_pixel_offset),
      .rsp_row_mask     (rsp_row_mask),
      .rsp_out_color    (rsp_out_color),
      .rsp_last_row     (rsp_last_row)
   );

endmodule

// ===== rtl/gtr_ctrl.sv =====
// controller of the glyph text renderer: issues load and home, and sequences setup, row reads and cursor advance
// depends on gtr_pkg and assert_macros.svh
`include "assert_macros.svh"

module gtr_ctrl
   import gtr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [1:0] command,
   output logic       busy,
   output dp_cmd_type dp_cmd
);

   ctrl_state_type   state_ff, state_in;
   logic [ROW_W-1:0] row_ff, row_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         row_ff   <= '0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      dp_cmd   = '0;
      dp_cmd.row = row_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (command)
                  CMD_DRAW: begin
                     dp_cmd.latch = 1'b1;
                     state_in     = ST_SETUP;
                  end
                  CMD_LOAD: dp_cmd.load = 1'b1;
                  CMD_HOME: dp_cmd.home = 1'b1;
                  default: ;
               endcase
            end
         end
         ST_SETUP: begin
            dp_cmd.setup = 1'b1;
            row_in       = '0;
            state_in     = ST_ROWS;
         end
         ST_ROWS: begin
            dp_cmd.read = 1'b1;
            dp_cmd.last = (row_ff == LAST_ROW);
            row_in      = row_ff + 1'b1;
            if (row_ff == LAST_ROW) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            dp_cmd.advance = 1'b1;
            state_in       = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   `GTR_ASSERT_NEXT(a_rows_end, state_ff == ST_ROWS && row_ff == LAST_ROW, state_ff == ST_FINISH, "row sequence did not end after the last row")
   `GTR_ASSERT(a_idle_row, state_ff != ST_ROWS || busy, "row reads issued while not busy")
   `GTR_ASSERT_NEXT(a_setup_rows, state_ff == ST_SETUP, state_ff == ST_ROWS && row_ff == '0, "rows did not start at the first row")

endmodule

// ===== rtl/gtr_datapath.sv =====
// datapath of the glyph text renderer: font memory, cursor, row offset and result registers
// depends on gtr_pkg and assert_macros.svh
`include "assert_macros.svh"

module gtr_datapath
   import gtr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  dp_cmd_type  dp_cmd,
   input  logic [7:0]  req_char_code,
   input  logic [31:0] req_pen_color,
   input  logic [11:0] req_font_address,
   input  logic [7:0]  req_font_byte,
   input  logic [15:0] line_pitch,
   input  logic [15:0] screen_width,
   output logic        rsp_valid,
   output logic [31:0] rsp_pixel_offset,
   output logic [7:0]  rsp_row_mask,
   output logic [31:0] rsp_out_color,
   output logic        rsp_last_row
);

   logic [7:0]         font_mem [STORE_DEPTH];
   logic [7:0]         mem_q_ff;
   logic [GLYPH_W-1:0] glyph_ff;
   logic [31:0]        color_ff;
   logic [31:0]        offset_ff;
   logic [31:0]        row_off_ff;
   logic               valid_ff;
   logic               last_ff;
   logic [15:0]        cursor_x_ff, cursor_x_in;
   logic [15:0]        cursor_y_ff, cursor_y_in;
   logic [31:0]        row0_offset;
   logic [ADDR_W-1:0]  rd_addr;
   logic [16:0]        next_x;
   logic [17:0]        next_x_end;
   logic [16:0]        next_y;

   // font memory, written by load and read one row per cycle
   assign rd_addr = {glyph_ff, dp_cmd.row};

   always_ff @(posedge clock) begin
      if (dp_cmd.load) begin
         font_mem[req_font_address] <= req_font_byte;
      end
      if (dp_cmd.read) begin
         mem_q_ff <= font_mem[rd_addr];
      end
   end

   // draw item payload and row offset accumulation
   assign row0_offset = ({16'd0, cursor_y_ff} * {16'd0, line_pitch}) + {16'd0, cursor_x_ff};

   always_ff @(posedge clock) begin
      if (dp_cmd.latch) begin
         glyph_ff <= req_char_code[GLYPH_W-1:0];
         color_ff <= req_pen_color;
      end
      if (dp_cmd.setup) begin
         offset_ff <= row0_offset;
      end else if (dp_cmd.read) begin
         offset_ff <= offset_ff + {16'd0, line_pitch};
      end
      if (dp_cmd.read) begin
         row_off_ff <= offset_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         last_ff  <= 1'b0;
      end else begin
         valid_ff <= dp_cmd.read;
         last_ff  <= dp_cmd.read & dp_cmd.last;
      end
   end

   // cursor home, and cursor advance with wrap and y saturation
   assign next_x     = {1'b0, cursor_x_ff} + {1'b0, CELL_W};
   assign next_x_end = {1'b0, next_x} + {2'b00, CELL_W};
   assign next_y     = {1'b0, cursor_y_ff} + {1'b0, CELL_H};

   always_comb begin
      cursor_x_in = cursor_x_ff;
      cursor_y_in = cursor_y_ff;
      priority if (dp_cmd.home) begin
         cursor_x_in = '0;
         cursor_y_in = '0;
      end else if (dp_cmd.advance) begin
         if (next_x_end > {2'b00, screen_width}) begin
            cursor_x_in = '0;
            cursor_y_in = next_y[16] ? Y_MAX : next_y[15:0];
         end else begin
            cursor_x_in = next_x[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_x_ff <= '0;
         cursor_y_ff <= '0;
      end else begin
         cursor_x_ff <= cursor_x_in;
         cursor_y_ff <= cursor_y_in;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_pixel_offset = row_off_ff;
   assign rsp_row_mask     = mem_q_ff;
   assign rsp_out_color    = color_ff;
   assign rsp_last_row     = last_ff;

   `GTR_ASSERT(a_last_valid, !last_ff || valid_ff, "last row flagged without a transfer")
   `GTR_ASSERT_NEXT(a_cursor_step, dp_cmd.advance, cursor_x_ff == '0 || cursor_x_ff == $past(cursor_x_ff) + CELL_W, "cursor x moved by other than one cell")
   `GTR_ASSERT_NEXT(a_last_follows, last_ff, !valid_ff, "transfer right after the last row")

endmodule
